// ===== rtl/gf2_matrix_vector_multiply_unit_macros.svh =====
// ----------------------------------------------------------------------------
// GF(2) matrix-vector multiply unit: assertion macros
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef GF2_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define GF2_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

// same-cycle implication
`define GMVM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GMVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/gmvm_pkg.sv =====
// ----------------------------------------------------------------------------
// GF(2) matrix-vector multiply unit: package
// Sizes of the stored matrix, the vector and the transfer words.
// ----------------------------------------------------------------------------
package gmvm_pkg;

	localparam int FIELD_BITS    = 192;
	localparam int WORDS_PER_ROW = 3;
	localparam int WORD_BITS     = 64;

	localparam int IN_WORDS  = 3;
	localparam int PAD_WORDS = 4;
	localparam int ROW_BITS  = WORDS_PER_ROW * WORD_BITS;
	localparam int IN_BITS   = IN_WORDS * WORD_BITS;
	localparam int PAD_BITS  = PAD_WORDS * WORD_BITS;
	localparam int LIVE_BITS = (FIELD_BITS < ROW_BITS) ? FIELD_BITS : ROW_BITS;
	localparam int ROW_AW    = $clog2(FIELD_BITS);
	localparam int IDX_BITS  = 8;

	typedef enum logic {
		CMD_LOAD     = 1'b0,
		CMD_MULTIPLY = 1'b1
	} cmd_t;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [ROW_BITS-1:0]  row_t;
	typedef logic [IN_BITS-1:0]   wide_t;

endpackage

// ===== rtl/gf2_matrix_vector_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// GF(2) matrix-vector multiply unit
// Stores a bit matrix one row per transfer and multiplies it by a vector,
// XORing in an addend, by walking the rows through one shared XOR unit.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | cmd, row_index, data_word0-2, addend_word0-2
//  out     | out_valid / out_ready| result_word0-2
//
//  A multiply reads one matrix row from the row memory per cycle and XORs
//  it in where the vector bit is set.
//  in_ready is high only while the sequencer is idle.
//  A finished result waits in the output register; a multiply that ends
//  while it is still held stalls until it is taken.
//  Reset clears control state only; the row memory is undefined until loaded.
// ----------------------------------------------------------------------------
module gf2_matrix_vector_multiply_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [7:0]            row_index,
	input  gmvm_pkg::word_t       data_word0,
	input  gmvm_pkg::word_t       data_word1,
	input  gmvm_pkg::word_t       data_word2,
	input  gmvm_pkg::word_t       addend_word0,
	input  gmvm_pkg::word_t       addend_word1,
	input  gmvm_pkg::word_t       addend_word2,
	output logic                  out_valid,
	input  logic                  out_ready,
	output gmvm_pkg::word_t       result_word0,
	output gmvm_pkg::word_t       result_word1,
	output gmvm_pkg::word_t       result_word2
);
	import gmvm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                 state_q;
	logic [ROW_AW-1:0]      cnt_q;
	logic [LIVE_BITS-1:0]   vec_q;
	wide_t                  acc_q;
	logic                   valid_s1;
	logic                   bit_s1;
	row_t                   rd_s1;
	row_t                   mem [FIELD_BITS];

	logic                   in_xfer;
	logic                   out_free;
	logic                   mem_we;
	logic [PAD_BITS-1:0]    data_pad;
	wide_t                  row_wide;
	wide_t                  acc_next;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;
	assign data_pad = PAD_BITS'({data_word2, data_word1, data_word0});
	assign mem_we   = in_xfer && (cmd_t'(cmd) == CMD_LOAD)
		&& ({1'b0, row_index} < (IDX_BITS + 1)'(FIELD_BITS));

	assign row_wide = IN_BITS'(PAD_BITS'(rd_s1));
	assign acc_next = (valid_s1 && bit_s1) ? (acc_q ^ row_wide) : acc_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[row_index[ROW_AW-1:0]] <= data_pad[ROW_BITS-1:0];
		end
		rd_s1 <= mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_RUN);
			if (out_valid && out_ready && (state_q != ST_FINISH)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && (cmd_t'(cmd) == CMD_MULTIPLY)) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (cnt_q == ROW_AW'(LIVE_BITS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		bit_s1 <= vec_q[0];
		case (state_q)
			ST_IDLE: begin
				vec_q <= data_pad[LIVE_BITS-1:0];
				acc_q <= {addend_word2, addend_word1, addend_word0};
			end
			ST_RUN: begin
				vec_q <= vec_q >> 1;
				acc_q <= acc_next;
			end
			ST_DRAIN: begin
				acc_q <= acc_next;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
		if ((state_q == ST_FINISH) && out_free) begin
			result_word0 <= acc_q[WORD_BITS-1:0];
			result_word1 <= acc_q[2*WORD_BITS-1:WORD_BITS];
			result_word2 <= acc_q[3*WORD_BITS-1:2*WORD_BITS];
		end
	end

endmodule

// ===== rtl/gmvm_checker.sv =====
// ----------------------------------------------------------------------------
// GF(2) matrix-vector multiply unit: port checker
// Watches the unit's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`include "gf2_matrix_vector_multiply_unit_macros.svh"

module gmvm_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            cmd,
	input logic            out_valid,
	input logic            out_ready,
	input gmvm_pkg::word_t result_word0,
	input gmvm_pkg::word_t result_word1,
	input gmvm_pkg::word_t result_word2
);
	import gmvm_pkg::*;

	logic stall;
	logic mul_xfer;
	logic load_xfer;

	assign stall     = out_valid && !out_ready;
	assign mul_xfer  = in_valid && in_ready && (cmd_t'(cmd) == CMD_MULTIPLY);
	assign load_xfer = in_valid && in_ready && (cmd_t'(cmd) == CMD_LOAD);

	`GMVM_ASSERT_NEXT(a_out_hold, stall, out_valid, "result dropped while stalled")
	`GMVM_ASSERT_NEXT(a_out_stable, stall, $stable(result_word0) && $stable(result_word1) && $stable(result_word2), "result changed while stalled")
	`GMVM_ASSERT_NEXT(a_mul_busy, mul_xfer, !in_ready, "input open right after a multiply")
	`GMVM_ASSERT_NEXT(a_load_free, load_xfer, in_ready, "input closed after a row load")

endmodule

bind gf2_matrix_vector_multiply_unit gmvm_checker u_gmvm_checker (.*);
